@@ hdl/gs_pkg.sv @@
// Shared types, widths and register codes for the Gray-Scott cell update.
// No dependencies; imported by every module under hdl/.
package gs_pkg;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Fixed point format of data values: signed Q3.FRAC_BITS; config registers unsigned Q3.FRAC_BITS.
  localparam int FRAC_BITS  = 20;
  localparam int W_DATA     = 24;
  localparam int W_REG      = 23;
  localparam int W_CFG_IDX  = 3;
  localparam int W_CFG_DATA = 32;

  // Intermediate widths; a floored product keeps (product width - FRAC_BITS) bits.
  localparam int W_LAP    = W_DATA + 3;                                // 5-point Laplacian
  localparam int W_UV_P   = 2 * W_DATA;                                // uc*vc
  localparam int W_UV     = max2(W_UV_P - FRAC_BITS, 1);
  localparam int W_UVV_P  = W_UV + W_DATA;                             // uv*vc
  localparam int W_UVV    = max2(W_UVV_P - FRAC_BITS, 1);
  localparam int W_FK     = W_REG + 1;                                 // F+k, unsigned
  localparam int W_UCF_P  = (W_DATA + 1) + (W_REG + 1);                // (-uc)*F
  localparam int W_UCF    = max2(W_UCF_P - FRAC_BITS, 1);
  localparam int W_FTERM  = max2(W_UCF, W_REG + 1) + 1;                // F + floor(-uc*F)
  localparam int W_K_P    = W_DATA + W_FK + 1;                         // vc*(F+k)
  localparam int W_KTERM  = max2(W_K_P - FRAC_BITS, 1);
  localparam int W_DL_P   = W_LAP + W_REG + 1;                         // Lap*D
  localparam int W_DL     = max2(W_DL_P - FRAC_BITS, 1);
  localparam int W_DELTA  = max2(max2(W_DL, W_UVV), max2(W_FTERM, W_KTERM)) + 2;
  localparam int W_STEP_P = W_DELTA + W_REG + 1;                       // delta*dt
  localparam int W_STEP   = max2(W_STEP_P - FRAC_BITS, 1);
  localparam int W_SUM    = max2(W_STEP, W_DATA) + 1;

  localparam int OUT_MAX = 2 ** (W_DATA - 1) - 1;
  localparam int OUT_MIN = -(2 ** (W_DATA - 1));

  // Register indexes on the config port.
  localparam logic [W_CFG_IDX-1:0] IDX_DIFF_U    = 3'd0;
  localparam logic [W_CFG_IDX-1:0] IDX_DIFF_V    = 3'd1;
  localparam logic [W_CFG_IDX-1:0] IDX_FEED_RATE = 3'd2;
  localparam logic [W_CFG_IDX-1:0] IDX_KILL_RATE = 3'd3;
  localparam logic [W_CFG_IDX-1:0] IDX_TIME_STEP = 3'd4;

  localparam logic [W_REG-1:0] RST_DIFF_U    = 23'd167772;
  localparam logic [W_REG-1:0] RST_DIFF_V    = 23'd83886;
  localparam logic [W_REG-1:0] RST_FEED_RATE = 23'd62915;
  localparam logic [W_REG-1:0] RST_KILL_RATE = 23'd65012;
  localparam logic [W_REG-1:0] RST_TIME_STEP = 23'd1048576;

  typedef struct packed {
    logic [W_REG-1:0] diff_u;
    logic [W_REG-1:0] diff_v;
    logic [W_REG-1:0] feed_rate;
    logic [W_REG-1:0] kill_rate;
    logic [W_REG-1:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [W_DATA-1:0] u_center;
    logic signed [W_DATA-1:0] u_west;
    logic signed [W_DATA-1:0] u_east;
    logic signed [W_DATA-1:0] u_north;
    logic signed [W_DATA-1:0] u_south;
    logic signed [W_DATA-1:0] v_center;
    logic signed [W_DATA-1:0] v_west;
    logic signed [W_DATA-1:0] v_east;
    logic signed [W_DATA-1:0] v_north;
    logic signed [W_DATA-1:0] v_south;
  } stencil_t;

  // Rates of change handed from the term pipeline to the Euler step.
  typedef struct packed {
    logic signed [W_DATA-1:0]  uc;
    logic signed [W_DATA-1:0]  vc;
    logic signed [W_DELTA-1:0] du;
    logic signed [W_DELTA-1:0] dv;
  } delta_t;

endpackage

@@ hdl/gs_cfg_regs.sv @@
// Configuration register file: diffusion, feed, kill rates and time step.
// Depends on gs_pkg.
module gs_cfg_regs import gs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [W_CFG_IDX-1:0]  cfg_index,
  input  logic [W_CFG_DATA-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_u    <= RST_DIFF_U;
      cfg.diff_v    <= RST_DIFF_V;
      cfg.feed_rate <= RST_FEED_RATE;
      cfg.kill_rate <= RST_KILL_RATE;
      cfg.time_step <= RST_TIME_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        IDX_DIFF_U:    cfg.diff_u    <= cfg_data[W_REG-1:0];
        IDX_DIFF_V:    cfg.diff_v    <= cfg_data[W_REG-1:0];
        IDX_FEED_RATE: cfg.feed_rate <= cfg_data[W_REG-1:0];
        IDX_KILL_RATE: cfg.kill_rate <= cfg_data[W_REG-1:0];
        IDX_TIME_STEP: cfg.time_step <= cfg_data[W_REG-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  a_wr_time_step: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && !rst && cfg_index == IDX_TIME_STEP
    |=> cfg.time_step == $past(cfg_data[W_REG-1:0]))
    else $error("time_step write not taken");

endmodule

@@ hdl/gs_terms.sv @@
// Three-stage pipeline: Laplacians, uvv, feed and kill terms, rates du/dv.
// Depends on gs_pkg; config comes from gs_cfg_regs.
module gs_terms import gs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  stencil_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output delta_t   out_data
);

  // stage control: a stage holds when full and the one after it holds
  logic [2:0] vld;
  logic [2:0] hold;

  always_comb begin
    hold[2] = vld[2] && out_stall;
    hold[1] = vld[1] && hold[2];
    hold[0] = vld[0] && hold[1];
  end

  assign in_stall  = hold[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (!hold[0]) vld[0] <= in_valid;
      if (!hold[1]) vld[1] <= vld[0];
      if (!hold[2]) vld[2] <= vld[1];
    end
  end

  // ---- stage 1: Laplacians, uc*vc, (-uc)*F, F+k
  logic signed [W_LAP-1:0]   lu_c, lv_c;
  logic signed [W_DATA:0]    neg_uc;
  logic signed [W_REG:0]     feed_s;
  logic signed [W_UV_P-1:0]  uv_p_c;
  logic signed [W_UCF_P-1:0] ucf_p_c;

  assign lu_c = W_LAP'(in_data.u_west) + W_LAP'(in_data.u_east)
              + W_LAP'(in_data.u_north) + W_LAP'(in_data.u_south)
              - (W_LAP'(in_data.u_center) <<< 2);
  assign lv_c = W_LAP'(in_data.v_west) + W_LAP'(in_data.v_east)
              + W_LAP'(in_data.v_north) + W_LAP'(in_data.v_south)
              - (W_LAP'(in_data.v_center) <<< 2);
  assign neg_uc  = -((W_DATA + 1)'(in_data.u_center));
  assign feed_s  = $signed({1'b0, cfg.feed_rate});
  assign uv_p_c  = in_data.u_center * in_data.v_center;
  assign ucf_p_c = neg_uc * feed_s;

  logic signed [W_DATA-1:0]  s1_uc, s1_vc;
  logic signed [W_LAP-1:0]   s1_lu, s1_lv;
  logic signed [W_UV_P-1:0]  s1_uv_p;
  logic signed [W_UCF_P-1:0] s1_ucf_p;
  logic        [W_FK-1:0]    s1_fk;

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      s1_uc    <= in_data.u_center;
      s1_vc    <= in_data.v_center;
      s1_lu    <= lu_c;
      s1_lv    <= lv_c;
      s1_uv_p  <= uv_p_c;
      s1_ucf_p <= ucf_p_c;
      s1_fk    <= W_FK'(cfg.feed_rate) + W_FK'(cfg.kill_rate);
    end
  end

  // ---- stage 2: uv*vc, D*Lap, vc*(F+k), fterm
  logic signed [W_UV-1:0]    uv_c;
  logic signed [W_UVV_P-1:0] uvv_p_c;
  logic signed [W_DL_P-1:0]  dlu_p_c, dlv_p_c;
  logic signed [W_K_P-1:0]   k_p_c;
  logic signed [W_FTERM-1:0] fterm_c;

  assign uv_c    = W_UV'(s1_uv_p >>> FRAC_BITS);
  assign uvv_p_c = uv_c * s1_vc;
  assign dlu_p_c = s1_lu * $signed({1'b0, cfg.diff_u});
  assign dlv_p_c = s1_lv * $signed({1'b0, cfg.diff_v});
  assign k_p_c   = s1_vc * $signed({1'b0, s1_fk});
  assign fterm_c = W_FTERM'($signed({1'b0, cfg.feed_rate}))
                 + W_FTERM'(W_UCF'(s1_ucf_p >>> FRAC_BITS));

  logic signed [W_DATA-1:0]  s2_uc, s2_vc;
  logic signed [W_UVV_P-1:0] s2_uvv_p;
  logic signed [W_DL_P-1:0]  s2_dlu_p, s2_dlv_p;
  logic signed [W_K_P-1:0]   s2_k_p;
  logic signed [W_FTERM-1:0] s2_fterm;

  always_ff @(posedge clk) begin
    if (!hold[1]) begin
      s2_uc    <= s1_uc;
      s2_vc    <= s1_vc;
      s2_uvv_p <= uvv_p_c;
      s2_dlu_p <= dlu_p_c;
      s2_dlv_p <= dlv_p_c;
      s2_k_p   <= k_p_c;
      s2_fterm <= fterm_c;
    end
  end

  // ---- stage 3: du = Du*Lu - uvv + fterm, dv = Dv*Lv + uvv - kterm
  logic signed [W_DELTA-1:0] uvv_c, dlu_c, dlv_c, kterm_c;

  assign uvv_c   = W_DELTA'(W_UVV'(s2_uvv_p >>> FRAC_BITS));
  assign dlu_c   = W_DELTA'(W_DL'(s2_dlu_p >>> FRAC_BITS));
  assign dlv_c   = W_DELTA'(W_DL'(s2_dlv_p >>> FRAC_BITS));
  assign kterm_c = W_DELTA'(W_KTERM'(s2_k_p >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!hold[2]) begin
      out_data.uc <= s2_uc;
      out_data.vc <= s2_vc;
      out_data.du <= dlu_c - uvv_c + W_DELTA'(s2_fterm);
      out_data.dv <= dlv_c + uvv_c - kterm_c;
    end
  end

endmodule

@@ hdl/gs_euler.sv @@
// Two-stage Euler step: delta*dt, add to the centre value, saturate.
// Depends on gs_pkg; fed by gs_terms.
module gs_euler import gs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  delta_t                   in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [W_DATA-1:0] u_next,
  output logic signed [W_DATA-1:0] v_next,
  output logic                     clipped
);

  localparam logic signed [W_SUM-1:0] SUM_MAX = W_SUM'(OUT_MAX);
  localparam logic signed [W_SUM-1:0] SUM_MIN = W_SUM'(OUT_MIN);

  logic [1:0] vld;
  logic [1:0] hold;

  assign hold[1]   = vld[1] && out_stall;
  assign hold[0]   = vld[0] && hold[1];
  assign in_stall  = hold[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (!hold[0]) vld[0] <= in_valid;
      if (!hold[1]) vld[1] <= vld[0];
    end
  end

  // ---- stage 4: products with dt
  logic signed [W_REG:0]      dt_s;
  logic signed [W_DATA-1:0]   s4_uc, s4_vc;
  logic signed [W_STEP_P-1:0] s4_pu, s4_pv;

  assign dt_s = $signed({1'b0, cfg.time_step});

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      s4_uc <= in_data.uc;
      s4_vc <= in_data.vc;
      s4_pu <= in_data.du * dt_s;
      s4_pv <= in_data.dv * dt_s;
    end
  end

  // ---- stage 5: accumulate and clamp
  logic signed [W_SUM-1:0] sum_u, sum_v;
  logic                    hi_u, lo_u, hi_v, lo_v;

  assign sum_u = W_SUM'(s4_uc) + W_SUM'(W_STEP'(s4_pu >>> FRAC_BITS));
  assign sum_v = W_SUM'(s4_vc) + W_SUM'(W_STEP'(s4_pv >>> FRAC_BITS));
  assign hi_u  = sum_u > SUM_MAX;
  assign lo_u  = sum_u < SUM_MIN;
  assign hi_v  = sum_v > SUM_MAX;
  assign lo_v  = sum_v < SUM_MIN;

  always_ff @(posedge clk) begin
    if (!hold[1]) begin
      u_next  <= hi_u ? W_DATA'(OUT_MAX) : (lo_u ? W_DATA'(OUT_MIN) : sum_u[W_DATA-1:0]);
      v_next  <= hi_v ? W_DATA'(OUT_MAX) : (lo_v ? W_DATA'(OUT_MIN) : sum_v[W_DATA-1:0]);
      clipped <= hi_u || lo_u || hi_v || lo_v;
    end
  end

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (u_next == W_DATA'(OUT_MAX)) || (u_next == W_DATA'(OUT_MIN)) ||
      (v_next == W_DATA'(OUT_MAX)) || (v_next == W_DATA'(OUT_MIN)))
    else $error("clipped set with no result at a rail");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[0] && vld[1])
    else $error("euler stage stalls upstream with a bubble inside");

endmodule

@@ hdl/gray_scott_cell_update.sv @@
// Top level of the Gray-Scott cell update: config registers, term pipeline
// and Euler step. Depends on gs_pkg, gs_cfg_regs, gs_terms, gs_euler.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one cell: centre and four
//    neighbours of U and V, signed Q3.20. A transfer happens on a rising
//    edge with in_valid high and in_stall low.
//  - Output channel (out_valid/out_stall) returns u_next, v_next and the
//    clipped flag, one result per input, in input order.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//    five rate registers; cfg_ready is always high, low 23 data bits used,
//    indexes past the list are dropped. Write only while the pipe is empty.
//  - Throughput: one cell per cycle while out_stall is low; full stages hold
//    while it is high. Pipeline: five register stages (sums/first products,
//    second products, rate adds, dt products, accumulate and clamp); the
//    result leaves the last of them, the output register.
//  - When the receiver stalls, full stages hold and empty stages keep
//    filling, so in_stall rises only once all five stages are occupied.
//  - rst (synchronous) empties the pipeline and loads the default rates.
module gray_scott_cell_update import gs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // config write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [W_CFG_IDX-1:0]     cfg_index,
  input  logic [W_CFG_DATA-1:0]    cfg_data,
  // cell input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [W_DATA-1:0] u_center,
  input  logic signed [W_DATA-1:0] u_west,
  input  logic signed [W_DATA-1:0] u_east,
  input  logic signed [W_DATA-1:0] u_north,
  input  logic signed [W_DATA-1:0] u_south,
  input  logic signed [W_DATA-1:0] v_center,
  input  logic signed [W_DATA-1:0] v_west,
  input  logic signed [W_DATA-1:0] v_east,
  input  logic signed [W_DATA-1:0] v_north,
  input  logic signed [W_DATA-1:0] v_south,
  // result
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [W_DATA-1:0] u_next,
  output logic signed [W_DATA-1:0] v_next,
  output logic                     clipped
);

  cfg_t     cfg;
  stencil_t stencil;
  delta_t   delta;
  logic     delta_valid;
  logic     delta_stall;

  // gather the stencil ports into one word
  assign stencil.u_center = u_center;
  assign stencil.u_west   = u_west;
  assign stencil.u_east   = u_east;
  assign stencil.u_north  = u_north;
  assign stencil.u_south  = u_south;
  assign stencil.v_center = v_center;
  assign stencil.v_west   = v_west;
  assign stencil.v_east   = v_east;
  assign stencil.v_north  = v_north;
  assign stencil.v_south  = v_south;

  gs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stages 1-3: Laplacians, reaction terms, du/dv
  gs_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (stencil),
    .out_valid (delta_valid),
    .out_stall (delta_stall),
    .out_data  (delta)
  );

  // stages 4-5: scale by dt, add, saturate; stage 5 is the output register
  gs_euler u_euler (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (delta_valid),
    .in_stall  (delta_stall),
    .in_data   (delta),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .u_next    (u_next),
    .v_next    (v_next),
    .clipped   (clipped)
  );

  // backpressure reaches the input only from a stalled, full output
  a_in_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule
